FILE: rtl/core/wea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekly event alarm table package
// Shared types, codes and the day-code match rule.
// ----------------------------------------------------------------------------
package wea_pkg;

  localparam int MAX_SLOTS_DEF = 16;
  localparam int MAX_LIGHT     = 255;
  localparam int DAY_MINUTES   = 1440;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ID    = 3'd1;
  localparam logic [2:0] ST_BAD_TIME  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  localparam logic [3:0] DAY_SUN     = 4'd0;
  localparam logic [3:0] DAY_MON     = 4'd1;
  localparam logic [3:0] DAY_FRI     = 4'd5;
  localparam logic [3:0] DAY_SAT     = 4'd6;
  localparam logic [3:0] DAY_EVERY   = 4'd7;
  localparam logic [3:0] DAY_WEEKDAY = 4'd8;
  localparam logic [3:0] DAY_WEEKEND = 4'd9;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [8:0]  light_id;
    logic [3:0]  day_code;
    logic [10:0] minute_of_day;
    logic        turn_on;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       command_valid;
    logic [7:0] command_light;
    logic       command_on;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic        used;
    logic [7:0]  light;
    logic [3:0]  day;
    logic [10:0] minute;
    logic        on;
  } entry_t;

  function automatic logic day_match(input logic [3:0] ev, input logic [3:0] cur);
    day_match = (ev == DAY_EVERY) || (ev == cur) ||
                ((ev == DAY_WEEKEND) && ((cur == DAY_SAT) || (cur == DAY_SUN))) ||
                ((ev == DAY_WEEKDAY) && (cur >= DAY_MON) && (cur <= DAY_FRI));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/wea_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table cell
// Holds one event entry and passes it on to its neighbour while shifting.
// ----------------------------------------------------------------------------
module wea_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             shift_en,
  input  wire wea_pkg::entry_t  d,
  output wea_pkg::entry_t       q
);

  logic            used_r;
  wea_pkg::entry_t entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (shift_en) begin
      used_r <= d.used;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= d;
    end
  end

  always_comb begin
    q      = entry_r;
    q.used = used_r;
  end

endmodule
`default_nettype wire

FILE: rtl/core/wea_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table controller
// Runs one rotation of the cell chain for each transaction not answered
// at once, editing the entry at the head and issuing results.
// ----------------------------------------------------------------------------
module wea_ctrl #(
  parameter int MAX_SLOTS = wea_pkg::MAX_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire wea_pkg::in_item_t  in_item,
  output logic                    busy,
  output logic                    shift_en,
  input  wire wea_pkg::entry_t    head,
  output wea_pkg::entry_t         tail,
  output logic                    out_valid,
  output wea_pkg::out_item_t      out_item
);

  localparam int CW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int UW = $clog2(MAX_SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                found_r, found_nxt;
  logic                pend_r, pend_nxt;
  logic [7:0]          pend_light_r, pend_light_nxt;
  logic                pend_on_r, pend_on_nxt;
  logic [UW-1:0]       used_cnt_r, used_cnt_nxt;
  wea_pkg::in_item_t   op_r, op_nxt;
  logic                out_valid_r, out_valid_nxt;
  wea_pkg::out_item_t  out_item_r, out_item_nxt;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    pend_nxt       = pend_r;
    pend_light_nxt = pend_light_r;
    pend_on_nxt    = pend_on_r;
    used_cnt_nxt   = used_cnt_r;
    op_nxt         = op_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = '0;
    tail           = head;
    shift_en       = (state_r == S_SCAN);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt            = in_item;
          out_valid_nxt     = 1'b1;
          out_item_nxt.last = 1'b1;
          priority if ((in_item.opcode == wea_pkg::OP_CREATE) &&
                       (in_item.light_id > 9'(wea_pkg::MAX_LIGHT))) begin
            out_item_nxt.status = wea_pkg::ST_BAD_ID;
          end else if ((in_item.opcode == wea_pkg::OP_CREATE) &&
                       (in_item.minute_of_day >= 11'(wea_pkg::DAY_MINUTES))) begin
            out_item_nxt.status = wea_pkg::ST_BAD_TIME;
          end else if ((in_item.opcode == wea_pkg::OP_REMOVE) &&
                       (used_cnt_r == '0)) begin
            out_item_nxt.status = wea_pkg::ST_EMPTY;
          end else if ((in_item.opcode == wea_pkg::OP_CREATE) ||
                       (in_item.opcode == wea_pkg::OP_REMOVE) ||
                       (in_item.opcode == wea_pkg::OP_TICK)) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_SCAN;
            cnt_nxt       = '0;
            found_nxt     = 1'b0;
            pend_nxt      = 1'b0;
          end else begin
            // spare opcode: plain closing result
          end
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(MAX_SLOTS - 1)) begin
          state_nxt = S_DONE;
        end
        unique case (op_r.opcode)
          wea_pkg::OP_CREATE: begin
            if (!found_r && !head.used) begin
              tail.used    = 1'b1;
              tail.light   = op_r.light_id[7:0];
              tail.day     = op_r.day_code;
              tail.minute  = op_r.minute_of_day;
              tail.on      = op_r.turn_on;
              found_nxt    = 1'b1;
              used_cnt_nxt = used_cnt_r + 1'b1;
            end
          end
          wea_pkg::OP_REMOVE: begin
            if (!found_r && head.used && ({1'b0, head.light} == op_r.light_id) &&
                (head.day == op_r.day_code) && (head.minute == op_r.minute_of_day)) begin
              tail.used    = 1'b0;
              found_nxt    = 1'b1;
              used_cnt_nxt = used_cnt_r - 1'b1;
            end
          end
          wea_pkg::OP_TICK: begin
            if (head.used && (head.minute == op_r.minute_of_day) &&
                wea_pkg::day_match(head.day, op_r.day_code)) begin
              if (pend_r) begin
                out_valid_nxt              = 1'b1;
                out_item_nxt.status        = wea_pkg::ST_OK;
                out_item_nxt.command_valid = 1'b1;
                out_item_nxt.command_light = pend_light_r;
                out_item_nxt.command_on    = pend_on_r;
              end
              pend_nxt       = 1'b1;
              pend_light_nxt = head.light;
              pend_on_nxt    = head.on;
            end
          end
          default: ;
        endcase
      end
      S_DONE: begin
        state_nxt         = S_IDLE;
        out_valid_nxt     = 1'b1;
        out_item_nxt.last = 1'b1;
        unique case (op_r.opcode)
          wea_pkg::OP_CREATE:
            out_item_nxt.status = found_r ? wea_pkg::ST_OK : wea_pkg::ST_FULL;
          wea_pkg::OP_REMOVE:
            out_item_nxt.status = found_r ? wea_pkg::ST_OK : wea_pkg::ST_NOT_FOUND;
          default: begin
            out_item_nxt.status = wea_pkg::ST_OK;
            if (pend_r) begin
              out_item_nxt.command_valid = 1'b1;
              out_item_nxt.command_light = pend_light_r;
              out_item_nxt.command_on    = pend_on_r;
            end
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_cnt_r  <= used_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    found_r      <= found_nxt;
    pend_r       <= pend_nxt;
    pend_light_r <= pend_light_nxt;
    pend_on_r    <= pend_on_nxt;
    op_r         <= op_nxt;
    out_item_r   <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

FILE: rtl/core/weekly_event_alarm_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekly event alarm table
// Scheduled on/off events per light id: create, remove and minute tick.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; in_item carries
// the opcode and its operands. Results appear on out_item for one cycle each,
// marked by out_valid; out_item.last flags the final result of a transaction.
// The receiver cannot stall, so every result is taken in the cycle it shows.
// Rejected creates, removes on an empty table and the spare opcode answer in
// the next cycle with busy staying low. Other transactions rotate the chain
// of MAX_SLOTS cells once, one entry past the head per cycle, then pass
// through a closing state that issues the final result; busy stays high
// through the rotation and the closing state. A tick issues one command
// result per matching entry, each held back until the next match passes
// the head; the last match rides on the closing result.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module weekly_event_alarm_table #(
  parameter int MAX_SLOTS = wea_pkg::MAX_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire wea_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output wea_pkg::out_item_t      out_item
);

  logic            shift_en;
  wea_pkg::entry_t head;
  wea_pkg::entry_t tail;
  wea_pkg::entry_t cell_q [MAX_SLOTS];

  assign head = cell_q[0];

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    wea_pkg::entry_t cell_d;
    if (i == MAX_SLOTS - 1) begin : g_tail
      assign cell_d = tail;
    end else begin : g_link
      assign cell_d = cell_q[i+1];
    end
    wea_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d        (cell_d),
      .q        (cell_q[i])
    );
  end

  wea_ctrl #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .shift_en  (shift_en),
    .head      (head),
    .tail      (tail),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

FILE: rtl/core/wea_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekly event alarm table port checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module wea_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire wea_pkg::out_item_t  out_item
);

  a_cmd_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.command_valid) |-> (out_item.status == wea_pkg::ST_OK))
    else $error("command result without ok status");

  a_no_bare : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last || out_item.command_valid))
    else $error("non-final result without a command");

  a_close : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_item.last))
    else $error("scan ended without a closing result");

  a_cause : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a transaction");

endmodule

bind weekly_event_alarm_table wea_checker u_wea_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire
